@@ hw/rtl/fts_pkg.sv @@
// fts_pkg: shared codes and types of the file transfer session controller
// event, phase, status, action and history mark codes, register indexes, step structs
// no dependencies
package fts_pkg;

  localparam int TimeWidthDefault = 32;
  localparam int CfgWidth         = 16;
  localparam int CfgIndexWidth    = 2;
  localparam int InDataWidth      = 40;
  localparam int OutDataWidth     = 16;

  // register indexes
  localparam logic [CfgIndexWidth-1:0] REG_CONNECTED       = 2'd0;
  localparam logic [CfgIndexWidth-1:0] REG_SEND            = 2'd1;
  localparam logic [CfgIndexWidth-1:0] REG_CONNECT_REQUEST = 2'd2;

  localparam logic [CfgWidth-1:0] CONNECTED_RESET       = 16'd60;
  localparam logic [CfgWidth-1:0] SEND_RESET            = 16'd120;
  localparam logic [CfgWidth-1:0] CONNECT_REQUEST_RESET = 16'd90;

  // events
  localparam logic [3:0] OP_CANCEL      = 4'd0;
  localparam logic [3:0] OP_PTT         = 4'd1;
  localparam logic [3:0] OP_FILE_OK     = 4'd2;
  localparam logic [3:0] OP_AUTH_CMD    = 4'd3;
  localparam logic [3:0] OP_AUTH_ERR    = 4'd4;
  localparam logic [3:0] OP_FILE_ERR    = 4'd5;
  localparam logic [3:0] OP_CANCEL_WAIT = 4'd6;
  localparam logic [3:0] OP_DISC        = 4'd7;
  localparam logic [3:0] OP_NEWSTATE    = 4'd8;
  localparam logic [3:0] OP_TICK        = 4'd9;
  localparam logic [3:0] OP_RCV_START   = 4'd10;
  localparam logic [3:0] OP_RCV_FRAME   = 4'd11;
  localparam logic [3:0] OP_RCV_DONE    = 4'd12;
  localparam logic [3:0] OP_START       = 4'd13;

  // phases
  localparam logic [3:0] PH_IDLE         = 4'd0;
  localparam logic [3:0] PH_CONNECTED    = 4'd1;
  localparam logic [3:0] PH_AUTH_REPLY   = 4'd2;
  localparam logic [3:0] PH_SEND_WAIT_OK = 4'd3;
  localparam logic [3:0] PH_SEND_WAIT    = 4'd4;
  localparam logic [3:0] PH_SENDING      = 4'd5;
  localparam logic [3:0] PH_RCV_WAIT_OK  = 4'd6;
  localparam logic [3:0] PH_RCV_WAIT     = 4'd7;
  localparam logic [3:0] PH_RECEIVING    = 4'd8;

  // status codes
  localparam logic [3:0] ST_NONE         = 4'd0;
  localparam logic [3:0] ST_CANCELLED    = 4'd1;
  localparam logic [3:0] ST_SENDING      = 4'd2;
  localparam logic [3:0] ST_AUTH_BUSY    = 4'd3;
  localparam logic [3:0] ST_AUTH_FAIL    = 4'd4;
  localparam logic [3:0] ST_SEND_ERR     = 4'd5;
  localparam logic [3:0] ST_DISCONNECTED = 4'd6;
  localparam logic [3:0] ST_REFRESH      = 4'd7;
  localparam logic [3:0] ST_SEND_TIMEOUT = 4'd8;
  localparam logic [3:0] ST_SEND_ACK     = 4'd9;
  localparam logic [3:0] ST_SEND_DONE    = 4'd10;
  localparam logic [3:0] ST_RECEIVING    = 4'd11;
  localparam logic [3:0] ST_RCV_TIMEOUT  = 4'd12;
  localparam logic [3:0] ST_RCV_ERR      = 4'd13;
  localparam logic [3:0] ST_RCV_DONE     = 4'd14;

  // actions
  localparam logic [2:0] ACT_NONE       = 3'd0;
  localparam logic [2:0] ACT_ABORT      = 3'd1;
  localparam logic [2:0] ACT_DISC       = 3'd2;
  localparam logic [2:0] ACT_AUTH_REPLY = 3'd3;
  localparam logic [2:0] ACT_AUTH_ERR   = 3'd4;
  localparam logic [2:0] ACT_SEND_CMD   = 3'd5;
  localparam logic [2:0] ACT_FEED       = 3'd6;

  // history marks
  localparam logic [1:0] MARK_NONE   = 2'd0;
  localparam logic [1:0] MARK_CANCEL = 2'd1;
  localparam logic [1:0] MARK_DONE   = 2'd2;

  typedef struct packed {
    logic [CfgWidth-1:0] connected_secs;
    logic [CfgWidth-1:0] send_secs;
    logic [CfgWidth-1:0] connect_request_secs;
  } fts_cfg_t;

  typedef struct packed {
    logic [3:0] op;
    logic [3:0] start_phase;
    logic       ptt_active;
    logic       link_disconnected;
    logic [31:0] now_seconds;
    logic       buffer_nonempty;
    logic       more_to_send;
  } fts_event_t;

  typedef struct packed {
    logic [3:0] next_phase;
    logic [3:0] status_code;
    logic [2:0] action;
    logic [1:0] history_mark;
  } fts_result_t;

  typedef struct packed {
    logic                load_base;
    logic                load_timeout;
    logic [CfgWidth-1:0] timeout_secs;
  } fts_update_t;

endpackage

@@ hw/rtl/fts_step.sv @@
// fts_step: next-phase decode of the file transfer session controller
// combinational: one event plus current state gives the result and the timer update
// depends on fts_pkg
module fts_step #(
  parameter int TIME_WIDTH = fts_pkg::TimeWidthDefault
) (
  input  logic [3:0]                   phase,
  input  logic [TIME_WIDTH-1:0]        timer_base,
  input  logic [fts_pkg::CfgWidth-1:0] timeout_secs,
  input  fts_pkg::fts_cfg_t            cfg,
  input  fts_pkg::fts_event_t          ev,
  output fts_pkg::fts_result_t         res,
  output fts_pkg::fts_update_t         upd
);
  import fts_pkg::*;

  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  timed_out;
  logic                  snd;
  logic                  rcv;
  logic [1:0]            snd_mark;

  // modular elapsed time, wraps at 2^TIME_WIDTH
  assign now_t     = TIME_WIDTH'(ev.now_seconds);
  assign elapsed   = now_t - timer_base;
  assign timed_out = elapsed > TIME_WIDTH'(timeout_secs);
  assign snd       = (phase >= PH_SEND_WAIT_OK) && (phase <= PH_SENDING);
  assign rcv       = (phase >= PH_RCV_WAIT_OK) && (phase <= PH_RECEIVING);
  assign snd_mark  = snd ? MARK_CANCEL : MARK_NONE;

  always_comb begin
    res.next_phase   = phase;
    res.status_code  = ST_NONE;
    res.action       = ACT_NONE;
    res.history_mark = MARK_NONE;
    upd.load_base    = 1'b0;
    upd.load_timeout = 1'b0;
    upd.timeout_secs = cfg.connected_secs;

    if (ev.op == OP_START) begin
      if ((ev.start_phase >= PH_SEND_WAIT_OK) && (ev.start_phase <= PH_RECEIVING)) begin
        res.next_phase   = ev.start_phase;
        upd.load_base    = 1'b1;
        upd.load_timeout = 1'b1;
      end
    end else if (snd || rcv) begin
      case (ev.op)
        OP_CANCEL: begin
          res.next_phase   = PH_IDLE;
          res.status_code  = ST_CANCELLED;
          res.action       = ACT_ABORT;
          res.history_mark = snd_mark;
        end
        OP_PTT: begin
          upd.load_base = ev.ptt_active;
        end
        OP_DISC, OP_NEWSTATE: begin
          if ((ev.op == OP_NEWSTATE) && !ev.link_disconnected) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.status_code  = ST_REFRESH;
          end else begin
            res.next_phase   = PH_IDLE;
            res.status_code  = ST_DISCONNECTED;
            res.action       = ACT_DISC;
            res.history_mark = snd_mark;
          end
        end
        OP_CANCEL_WAIT: begin
          if ((phase != PH_SENDING) && (phase != PH_RECEIVING)) begin
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_CANCELLED;
            res.history_mark = snd_mark;
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
          end
        end
        OP_FILE_OK: begin
          if (phase == PH_SEND_WAIT_OK) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            upd.timeout_secs = cfg.connect_request_secs;
            res.next_phase   = PH_SENDING;
            res.status_code  = ST_SENDING;
            res.action       = ACT_SEND_CMD;
          end else if (phase == PH_SENDING) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_SEND_ACK;
            res.history_mark = MARK_DONE;
          end
        end
        OP_AUTH_CMD: begin
          if ((phase == PH_SEND_WAIT_OK) || (phase == PH_RCV_WAIT)) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            upd.timeout_secs = cfg.send_secs;
            res.next_phase   = PH_AUTH_REPLY;
            res.status_code  = ST_AUTH_BUSY;
            res.action       = ACT_AUTH_REPLY;
          end
        end
        OP_AUTH_ERR: begin
          if ((phase == PH_SEND_WAIT_OK) || (phase == PH_RCV_WAIT)) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_AUTH_FAIL;
            res.action       = ACT_AUTH_ERR;
            res.history_mark = snd_mark;
          end
        end
        OP_FILE_ERR: begin
          if ((phase == PH_SEND_WAIT_OK) || (phase == PH_SENDING)) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_SEND_ERR;
            res.history_mark = MARK_CANCEL;
          end else if ((phase == PH_RCV_WAIT) || (phase == PH_RECEIVING)) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_RCV_ERR;
          end
        end
        OP_RCV_START: begin
          if (phase == PH_RCV_WAIT) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_RECEIVING;
            res.status_code  = ST_RECEIVING;
          end
        end
        OP_RCV_FRAME: begin
          if (phase == PH_RECEIVING) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.status_code  = ST_RECEIVING;
          end
        end
        OP_RCV_DONE: begin
          if (phase == PH_RECEIVING) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            res.next_phase   = PH_CONNECTED;
            res.status_code  = ST_RCV_DONE;
          end
        end
        OP_TICK: begin
          if ((phase == PH_SEND_WAIT) && ev.buffer_nonempty) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            upd.timeout_secs = cfg.send_secs;
            res.next_phase   = PH_SENDING;
            res.status_code  = ST_SENDING;
            res.action       = ACT_SEND_CMD;
          end else if ((phase == PH_RCV_WAIT_OK) && !ev.buffer_nonempty) begin
            upd.load_base    = 1'b1;
            upd.load_timeout = 1'b1;
            upd.timeout_secs = cfg.send_secs;
            res.next_phase   = PH_RECEIVING;
            res.status_code  = ST_RECEIVING;
          end else begin
            // sending always feeds, even when the same tick times out
            if (phase == PH_SENDING) begin
              res.action = ACT_FEED;
            end
            if ((phase == PH_SENDING) && !ev.more_to_send) begin
              res.status_code = ST_SEND_DONE;
            end else if (timed_out) begin
              upd.load_base    = 1'b1;
              upd.load_timeout = 1'b1;
              res.next_phase   = PH_CONNECTED;
              res.status_code  = snd ? ST_SEND_TIMEOUT : ST_RCV_TIMEOUT;
              res.history_mark = snd_mark;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/file_transfer_session_controller_top.sv @@
// file_transfer_session_controller_top: event-driven send/receive session controller
// input register, fts_step decode, result register, timeout registers
// depends on fts_pkg and fts_step
//
// Usage:
//   Events enter on the s_axis channel: s_axis_tuser carries the event code,
//   s_axis_tdata the event arguments and the current time in seconds. Each
//   event gives exactly one result on m_axis: next phase, status, action and
//   history mark. The three timeouts are to be written on the cfg port only
//   while no event is in flight; the block itself does not enforce this. An
//   index of 3 is ignored. An input transfer passes the input register, then
//   the decode into the result register, which raises m_axis_tvalid.
//   Throughput is one event per cycle unless the receiver stalls; phase, timer
//   base and timeout update at the same edge that loads the result register,
//   so the next event in the input register already sees them.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more event; s_axis_tready drops only while both
//   are full.
//   Synchronous reset returns to phase idle with timer base and timeout zero,
//   loads the timeout registers with 60, 120 and 90 seconds and empties both
//   registers of the pipe.
module file_transfer_session_controller_top #(
  parameter int TIME_WIDTH = fts_pkg::TimeWidthDefault
) (
  input  logic                                clk,
  input  logic                                rst,
  // event channel
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata, lowest bit up: start_phase[3:0], ptt_active[4], link_disconnected[5],
  // now_seconds[37:6], buffer_nonempty[38], more_to_send[39]
  input  logic [fts_pkg::InDataWidth-1:0]     s_axis_tdata,
  // tuser, lowest bit up: op[3:0]
  input  logic [3:0]                          s_axis_tuser,
  // result channel
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata, lowest bit up: next_phase[3:0], status_code[7:4], action[10:8],
  // history_mark[12:11], zero fill[15:13]
  output logic [fts_pkg::OutDataWidth-1:0]    m_axis_tdata,
  // configuration writes
  input  logic                                cfg_wr_en,
  input  logic [fts_pkg::CfgIndexWidth-1:0]   cfg_index,
  input  logic [fts_pkg::CfgWidth-1:0]        cfg_wr_data
);
  import fts_pkg::*;

  fts_cfg_t                cfg;
  logic                    in_valid;
  logic [3:0]              in_op;
  logic [InDataWidth-1:0]  in_data;
  fts_event_t              ev;
  logic                    advance;
  logic [3:0]              phase;
  logic [TIME_WIDTH-1:0]   timer_base;
  logic [CfgWidth-1:0]     timeout_secs;
  fts_result_t             res;
  fts_update_t             upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.connected_secs       <= CONNECTED_RESET;
      cfg.send_secs            <= SEND_RESET;
      cfg.connect_request_secs <= CONNECT_REQUEST_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_CONNECTED:       cfg.connected_secs       <= cfg_wr_data;
        REG_SEND:            cfg.send_secs            <= cfg_wr_data;
        REG_CONNECT_REQUEST: cfg.connect_request_secs <= cfg_wr_data;
        default: begin
        end
      endcase
    end
  end

  assign advance       = in_valid && (!m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !in_valid || !m_axis_tvalid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
    if (s_axis_tvalid && s_axis_tready) begin
      in_op   <= s_axis_tuser;
      in_data <= s_axis_tdata;
    end
  end

  assign ev.op                = in_op;
  assign ev.start_phase       = in_data[3:0];
  assign ev.ptt_active        = in_data[4];
  assign ev.link_disconnected = in_data[5];
  assign ev.now_seconds       = in_data[37:6];
  assign ev.buffer_nonempty   = in_data[38];
  assign ev.more_to_send      = in_data[39];

  fts_step #(
    .TIME_WIDTH (TIME_WIDTH)
  ) u_step (
    .phase        (phase),
    .timer_base   (timer_base),
    .timeout_secs (timeout_secs),
    .cfg          (cfg),
    .ev           (ev),
    .res          (res),
    .upd          (upd)
  );

  // session state moves with the transfer into the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      timer_base    <= '0;
      timeout_secs  <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (advance) begin
        phase <= res.next_phase;
        if (upd.load_base) begin
          timer_base <= TIME_WIDTH'(ev.now_seconds);
        end
        if (upd.load_timeout) begin
          timeout_secs <= upd.timeout_secs;
        end
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
    if (advance) begin
      m_axis_tdata <= {3'b000, res.history_mark, res.action, res.status_code, res.next_phase};
    end
  end

endmodule

@@ hw/rtl/fts_checker.sv @@
// fts_checker: port-level checks of the file transfer session controller
// watches the top level ports only; bound to the top level below
// depends on fts_pkg
module fts_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_axis_tvalid,
  input logic                              s_axis_tready,
  input logic                              m_axis_tvalid,
  input logic                              m_axis_tready,
  input logic [fts_pkg::OutDataWidth-1:0]  m_axis_tdata
);
  import fts_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // input only backs up when a result is waiting
  a_ready_only_full: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty result register");

  // an accepted event is followed by a valid result once it has passed the input and result registers
  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("no result after accepted event");

  // done mark comes only with a send ack back to connected
  a_done_mark: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[12:11] == MARK_DONE) |->
      (m_axis_tdata[7:4] == ST_SEND_ACK) && (m_axis_tdata[3:0] == PH_CONNECTED))
    else $error("done mark without send ack");

endmodule

bind file_transfer_session_controller_top fts_checker u_fts_checker (.*);
